// ===== hdl/rau_pkg.sv =====
// Package for the rational arithmetic unit: opcodes, default width and commands.
// Used by rau_ctrl, rau_dp and rational_arithmetic_unit_top; depends on nothing.
`timescale 1ns / 1ps
package rau_pkg;

  localparam int DefaultWidth = 32;
  localparam int FieldWidth   = 32;

  typedef enum logic [2:0] {
    OP_ADD = 3'd0,
    OP_SUB = 3'd1,
    OP_MUL = 3'd2,
    OP_DIV = 3'd3,
    OP_EQ  = 3'd4,
    OP_LT  = 3'd5,
    OP_NEG = 3'd6,
    OP_NOP = 3'd7
  } opcode_t;

  // Commands from the controller to the datapath.
  typedef enum logic [3:0] {
    CMD_IDLE    = 4'd0,
    CMD_LOAD    = 4'd1,  // capture operands
    CMD_MUL1    = 4'd2,  // first round of products
    CMD_MUL2    = 4'd3,  // second round of products / form raw fraction
    CMD_GCD_SET = 4'd4,  // load the GCD unit with the current fraction
    CMD_GCD     = 4'd5,  // one GCD step (one quotient bit)
    CMD_DIV_SET = 4'd6,  // load the division unit
    CMD_DIV     = 4'd7,  // one division step
    CMD_FIX     = 4'd8,  // apply signs and store reduced fraction
    CMD_DONE    = 4'd9   // present the result
  } cmd_t;

  typedef struct packed {
    logic gcd_done;
    logic div_done;
    logic zero_gcd;
    logic need_reduce;   // arithmetic path needs a GCD reduction
    logic second_pass;   // equal opcode has a second operand to reduce
  } status_t;

endpackage

// ===== hdl/rau_ctrl.sv =====
// Controller for the rational arithmetic unit: sequences the datapath.
// Depends on rau_pkg.
`timescale 1ns / 1ps
module rau_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  rau_pkg::status_t status,
  output rau_pkg::cmd_t    cmd,
  output logic             busy
);

  typedef enum logic [8:0] {
    S_IDLE    = 9'b000000001,
    S_MUL1    = 9'b000000010,
    S_MUL2    = 9'b000000100,
    S_GCD_SET = 9'b000001000,
    S_GCD     = 9'b000010000,
    S_DIV_SET = 9'b000100000,
    S_DIV     = 9'b001000000,
    S_FIX     = 9'b010000000,
    S_DONE    = 9'b100000000
  } state_t;

  state_t state, state_next;

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:    if (start) state_next = S_MUL1;
      S_MUL1:    state_next = S_MUL2;
      S_MUL2:    state_next = status.need_reduce ? S_GCD_SET : S_DONE;
      S_GCD_SET: state_next = S_GCD;
      S_GCD: begin
        if (status.gcd_done) state_next = status.zero_gcd ? S_FIX : S_DIV_SET;
      end
      S_DIV_SET: state_next = S_DIV;
      S_DIV:     if (status.div_done) state_next = S_FIX;
      S_FIX:     state_next = status.second_pass ? S_GCD_SET : S_DONE;
      S_DONE:    state_next = S_IDLE;
      default:   state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  // Command decode.
  always_comb begin
    case (state)
      S_IDLE:    cmd = start ? rau_pkg::CMD_LOAD : rau_pkg::CMD_IDLE;
      S_MUL1:    cmd = rau_pkg::CMD_MUL1;
      S_MUL2:    cmd = rau_pkg::CMD_MUL2;
      S_GCD_SET: cmd = rau_pkg::CMD_GCD_SET;
      S_GCD:     cmd = rau_pkg::CMD_GCD;
      S_DIV_SET: cmd = rau_pkg::CMD_DIV_SET;
      S_DIV:     cmd = rau_pkg::CMD_DIV;
      S_FIX:     cmd = rau_pkg::CMD_FIX;
      S_DONE:    cmd = rau_pkg::CMD_DONE;
      default:   cmd = rau_pkg::CMD_IDLE;
    endcase
  end

  assign busy = (state != S_IDLE);

endmodule

// ===== hdl/rau_dp.sv =====
// Datapath for the rational arithmetic unit: multipliers, a bit-serial GCD
// and a bit-serial dual divider. Depends on rau_pkg.
`timescale 1ns / 1ps
module rau_dp #(
  parameter int WIDTH = rau_pkg::DefaultWidth
) (
  input  logic                               clk,
  input  logic                               rst,
  input  rau_pkg::cmd_t                      cmd,
  input  logic [2:0]                         opcode,
  input  logic signed [rau_pkg::FieldWidth-1:0] left_num,
  input  logic signed [rau_pkg::FieldWidth-1:0] left_den,
  input  logic signed [rau_pkg::FieldWidth-1:0] right_num,
  input  logic signed [rau_pkg::FieldWidth-1:0] right_den,
  output rau_pkg::status_t                   status,
  output logic                               done,
  output logic signed [rau_pkg::FieldWidth-1:0] result_num,
  output logic signed [rau_pkg::FieldWidth-1:0] result_den,
  output logic                               compare_true
);

  localparam int CntW = $clog2(WIDTH + 1);
  localparam int FW   = rau_pkg::FieldWidth;

  // Operand registers.
  logic [2:0]       op;
  logic [WIDTH-1:0] ln, ld, rn, rd;
  // Products.
  logic [WIDTH-1:0] p0, p1, p2;
  // Fraction under reduction and first reduced result (for equal).
  logic [WIDTH-1:0] fn, fd;
  logic [WIDTH-1:0] an, ad;
  logic             pass;
  logic             need_reduce;
  logic             flag;
  // Result registers.
  logic [WIDTH-1:0] rnum, rden;
  // GCD unit: a mod b by restoring division, one bit a step.
  logic [WIDTH-1:0] gb, gq, grem;
  logic [CntW-1:0]  gcnt;
  logic             gbusy;
  logic             gdone;
  // Division unit: both magnitudes divided by g.
  logic [WIDTH-1:0] dqn, dqd, drn, drd, dg;
  logic [CntW-1:0]  dcnt;
  logic             ddone;

  function automatic logic [WIDTH-1:0] mag(input logic [WIDTH-1:0] v);
    mag = v[WIDTH-1] ? (~v + 1'b1) : v;
  endfunction

  function automatic logic [WIDTH-1:0] cut(input logic [FW-1:0] v);
    logic [63:0] e;
    e = {{(64-FW){v[FW-1]}}, v};
    cut = e[WIDTH-1:0];
  endfunction

  function automatic logic [FW-1:0] ext(input logic [WIDTH-1:0] v);
    logic [63:0] e;
    e = {{(64-WIDTH){v[WIDTH-1]}}, v};
    ext = e[FW-1:0];
  endfunction

  logic [2*WIDTH-1:0] m0, m1, m2;
  logic               lnan, rnan;

  assign lnan = (ld == '0);
  assign rnan = (rd == '0);

  // Products of the first round: ln*rd, rn*ld, ld*rd.
  assign m0 = ln * rd;
  assign m1 = rn * ld;
  assign m2 = ld * rd;

  // Operations that go through a GCD reduction once the raw fraction is formed.
  always_comb begin
    case (op)
      rau_pkg::OP_ADD, rau_pkg::OP_SUB, rau_pkg::OP_EQ: need_reduce = !lnan && !rnan;
      rau_pkg::OP_MUL, rau_pkg::OP_DIV, rau_pkg::OP_NEG: need_reduce = 1'b1;
      default: need_reduce = 1'b0;
    endcase
  end

  // One restoring step of gq mod gb.
  logic [WIDTH:0] gtrial;
  logic [WIDTH-1:0] gshift;
  assign gshift = {grem[WIDTH-2:0], gq[WIDTH-1]};
  assign gtrial = {grem, gq[WIDTH-1]} - {1'b0, gb};

  // One restoring step of the dual divider.
  logic [WIDTH:0] tn, td;
  assign tn = {drn, dqn[WIDTH-1]} - {1'b0, dg};
  assign td = {drd, dqd[WIDTH-1]} - {1'b0, dg};

  // Signed quotient and sign fix.
  logic [WIDTH-1:0] sqn, sqd, gsgn;
  logic             gneg;
  assign gneg = gsgn[WIDTH-1];
  assign sqn  = (fn[WIDTH-1] != gneg) ? (~dqn + 1'b1) : dqn;
  assign sqd  = (fd[WIDTH-1] != gneg) ? (~dqd + 1'b1) : dqd;

  always_ff @(posedge clk) begin
    if (rst) begin
      gbusy <= 1'b0;
      gdone <= 1'b0;
      ddone <= 1'b0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (cmd)
        rau_pkg::CMD_LOAD: begin
          op   <= opcode;
          ln   <= cut(left_num);
          ld   <= cut(left_den);
          rn   <= cut(right_num);
          rd   <= cut(right_den);
          pass <= 1'b0;
          flag <= 1'b0;
          rnum <= '0;
          rden <= '0;
        end
        rau_pkg::CMD_MUL1: begin
          p0 <= m0[WIDTH-1:0];
          p1 <= m1[WIDTH-1:0];
          p2 <= m2[WIDTH-1:0];
        end
        rau_pkg::CMD_MUL2: begin
          case (op)
            rau_pkg::OP_ADD, rau_pkg::OP_SUB: begin
              if (lnan) begin
                rnum <= rn; rden <= rd;
              end else if (rnan) begin
                rnum <= ln; rden <= ld;
              end else begin
                fn <= (op == rau_pkg::OP_ADD) ? p0 + p1 : p0 - p1;
                fd <= p2;
              end
            end
            rau_pkg::OP_MUL: begin
              fn <= ln * rn;
              fd <= p2;
            end
            rau_pkg::OP_DIV: begin
              fn <= p0;
              fd <= p1;
            end
            rau_pkg::OP_NEG: begin
              fn <= ~ln + 1'b1;
              fd <= ld;
            end
            rau_pkg::OP_EQ: begin
              if (!lnan && !rnan) begin
                fn <= ln;
                fd <= ld;
              end
            end
            rau_pkg::OP_LT: begin
              // Fix signs of cross products on the common denominator.
              if (!lnan && !rnan) begin
                flag <= ($signed(p2[WIDTH-1] ? ~p0 + 1'b1 : p0)
                        < $signed(p2[WIDTH-1] ? ~p1 + 1'b1 : p1));
              end
            end
            default: ;
          endcase
        end
        rau_pkg::CMD_GCD_SET: begin
          // gcd(|n|, |d|) with b = |d|; a mod b computed bit-serially.
          gb    <= mag(fd);
          gq    <= mag(fn);
          grem  <= '0;
          gcnt  <= '0;
          gbusy <= (mag(fd) != '0);
          gdone <= (mag(fd) == '0);
          gsgn  <= mag(fn);
        end
        rau_pkg::CMD_GCD: begin
          if (gbusy) begin
            if (gcnt == CntW'(WIDTH)) begin
              // Remainder ready: a <- b, b <- rem.
              gb   <= grem;
              gq   <= gb;
              gcnt <= '0;
              if (grem == '0) begin
                gbusy <= 1'b0;
                gdone <= 1'b1;
                gsgn  <= gb;
              end
              grem <= '0;
            end else begin
              gq   <= {gq[WIDTH-2:0], 1'b0};
              grem <= gtrial[WIDTH] ? gshift : gtrial[WIDTH-1:0];
              gcnt <= gcnt + 1'b1;
            end
          end
        end
        rau_pkg::CMD_DIV_SET: begin
          gdone <= 1'b0;
          dg    <= mag(gsgn);
          dqn   <= mag(fn);
          dqd   <= mag(fd);
          drn   <= '0;
          drd   <= '0;
          dcnt  <= '0;
          ddone <= 1'b0;
        end
        rau_pkg::CMD_DIV: begin
          // Exactly WIDTH steps; the quotients hold while the controller leaves.
          if (!ddone) begin
            if (dcnt == CntW'(WIDTH - 1)) ddone <= 1'b1;
            dcnt <= dcnt + 1'b1;
            drn  <= tn[WIDTH] ? {drn[WIDTH-2:0], dqn[WIDTH-1]} : tn[WIDTH-1:0];
            drd  <= td[WIDTH] ? {drd[WIDTH-2:0], dqd[WIDTH-1]} : td[WIDTH-1:0];
            dqn  <= {dqn[WIDTH-2:0], ~tn[WIDTH]};
            dqd  <= {dqd[WIDTH-2:0], ~td[WIDTH]};
          end
        end
        rau_pkg::CMD_FIX: begin
          gdone <= 1'b0;
          ddone <= 1'b0;
          if (op == rau_pkg::OP_EQ) begin
            if (!pass) begin
              an   <= (gsgn == '0) ? '0 : (sqd[WIDTH-1] ? ~sqn + 1'b1 : sqn);
              ad   <= (gsgn == '0) ? '0 : (sqd[WIDTH-1] ? ~sqd + 1'b1 : sqd);
              fn   <= rn;
              fd   <= rd;
              pass <= 1'b1;
            end else begin
              flag <= (gsgn == '0) ? (an == '0 && ad == '0) :
                      (an == (sqd[WIDTH-1] ? ~sqn + 1'b1 : sqn) &&
                       ad == (sqd[WIDTH-1] ? ~sqd + 1'b1 : sqd));
              pass <= 1'b0;
            end
          end else begin
            rnum <= (gsgn == '0) ? '0 : (sqd[WIDTH-1] ? ~sqn + 1'b1 : sqn);
            rden <= (gsgn == '0) ? '0 : (sqd[WIDTH-1] ? ~sqd + 1'b1 : sqd);
          end
        end
        rau_pkg::CMD_DONE: begin
          done <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  assign status.gcd_done    = gdone;
  assign status.div_done    = ddone;
  assign status.zero_gcd    = (gsgn == '0);
  assign status.need_reduce = need_reduce;
  assign status.second_pass = (op == rau_pkg::OP_EQ) && !pass;

  assign result_num   = done ? ext(rnum) : '0;
  assign result_den   = done ? ext(rden) : '0;
  assign compare_true = done & flag;

endmodule

// ===== hdl/rational_arithmetic_unit_top.sv =====
// Top level of the rational arithmetic unit.
// Instantiates rau_ctrl and rau_dp; depends on rau_pkg.
`timescale 1ns / 1ps
// One beat is accepted when start is high and busy is low; busy then stays high
// until the cycle that shows the result, where it falls, so the next beat may be
// accepted at the edge that ends that cycle. The result is on result_num, result_den
// and compare_true for exactly one cycle, marked by done, and the receiver cannot
// stall it, so it must be taken in that cycle. Less-than, the unused opcode, equality
// with a NaN operand and add or subtract with a NaN operand go from the products
// straight to done with no reduction. Zero over zero skips the remainder steps and
// the division. Any other reduction first runs k Euclid remainder steps (none when
// the denominator is zero, up to about 46 at 32 bits), each done bit-serially, and
// then divides both magnitudes by the GCD. Equality reduces both operands in turn.
module rational_arithmetic_unit_top #(
  parameter int WIDTH = rau_pkg::DefaultWidth
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  start,
  output logic                                  busy,
  input  logic [2:0]                            opcode,
  input  logic signed [rau_pkg::FieldWidth-1:0] left_num,
  input  logic signed [rau_pkg::FieldWidth-1:0] left_den,
  input  logic signed [rau_pkg::FieldWidth-1:0] right_num,
  input  logic signed [rau_pkg::FieldWidth-1:0] right_den,
  output logic                                  done,
  output logic signed [rau_pkg::FieldWidth-1:0] result_num,
  output logic signed [rau_pkg::FieldWidth-1:0] result_den,
  output logic                                  compare_true
);

  rau_pkg::cmd_t    cmd;
  rau_pkg::status_t status;

  // Sequencer.
  rau_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  // Arithmetic datapath.
  rau_dp #(.WIDTH(WIDTH)) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .opcode       (opcode),
    .left_num     (left_num),
    .left_den     (left_den),
    .right_num    (right_num),
    .right_den    (right_den),
    .status       (status),
    .done         (done),
    .result_num   (result_num),
    .result_den   (result_den),
    .compare_true (compare_true)
  );

endmodule

// ===== dv/testbench.sv =====
// Self-checking testbench for rational_arithmetic_unit_top at its default width.
// Holds its own fraction predictor in a small scoreboard class; depends on rau_pkg.
`timescale 1ns / 1ps
module testbench;

  typedef logic [rau_pkg::FieldWidth-1:0] word_t;

  typedef struct {
    word_t num;
    word_t den;
    logic  flag;
  } fraction_result_t;

  // Predicts each result from the operands of an accepted beat and checks results in order.
  class fraction_scoreboard;
    fraction_result_t awaited_results[$];
    int unsigned      mismatches;

    function new();
      mismatches = 0;
    endfunction

    function word_t magnitude(word_t v);
      return v[rau_pkg::FieldWidth-1] ? word_t'(0) - v : v;
    endfunction

    function word_t euclid(word_t a, word_t b);
      word_t t;
      while (b != 0) begin
        t = a % b;
        a = b;
        b = t;
      end
      return a;
    endfunction

    // Truncating signed division; a divisor of 2^31 counts as negative.
    function word_t signed_quotient(word_t x, word_t g);
      word_t q;
      q = magnitude(x) / magnitude(g);
      return (x[rau_pkg::FieldWidth-1] != g[rau_pkg::FieldWidth-1]) ? word_t'(0) - q : q;
    endfunction

    function fraction_result_t move_sign(fraction_result_t f);
      if (f.den[rau_pkg::FieldWidth-1]) begin
        f.num = word_t'(0) - f.num;
        f.den = word_t'(0) - f.den;
      end
      return f;
    endfunction

    function fraction_result_t reduced_fraction(word_t n, word_t d);
      fraction_result_t f;
      word_t            g;
      g = euclid(magnitude(n), magnitude(d));
      f.flag = 1'b0;
      f.num  = '0;
      f.den  = '0;
      if (g == 0) return f;
      f.num = signed_quotient(n, g);
      f.den = signed_quotient(d, g);
      return move_sign(f);
    endfunction

    // Addition passes a NaN operand's partner straight through, unreduced.
    function fraction_result_t fraction_sum(word_t ln, word_t ld, word_t rn, word_t rd);
      fraction_result_t f;
      f.flag = 1'b0;
      if (ld == 0) begin
        f.num = rn;
        f.den = rd;
      end else if (rd == 0) begin
        f.num = ln;
        f.den = ld;
      end else begin
        f = reduced_fraction(word_t'(ln * rd + rn * ld), word_t'(ld * rd));
      end
      return f;
    endfunction

    function fraction_result_t arithmetic_outcome(rau_pkg::opcode_t op, word_t ln, word_t ld,
                                                  word_t rn, word_t rd);
      fraction_result_t f, a, b;
      f.num  = '0;
      f.den  = '0;
      f.flag = 1'b0;
      case (op)
        rau_pkg::OP_ADD: f = fraction_sum(ln, ld, rn, rd);
        // A NaN left operand hands back the right one as given, not negated.
        rau_pkg::OP_SUB: f = (ld == 0) ? fraction_sum(ln, ld, rn, rd)
                                       : fraction_sum(ln, ld, word_t'(0) - rn, rd);
        rau_pkg::OP_MUL: f = reduced_fraction(word_t'(ln * rn), word_t'(ld * rd));
        rau_pkg::OP_DIV: f = reduced_fraction(word_t'(ln * rd), word_t'(ld * rn));
        rau_pkg::OP_EQ: begin
          if (ld != 0 && rd != 0) begin
            a = reduced_fraction(ln, ld);
            b = reduced_fraction(rn, rd);
            f.flag = (a.num == b.num) && (a.den == b.den);
          end
        end
        rau_pkg::OP_LT: begin
          // Cross-multiplied with wrap, signs moved to the numerators.
          if (ld != 0 && rd != 0) begin
            a.num = ln * rd;
            a.den = ld * rd;
            b.num = rn * ld;
            b.den = rd * ld;
            a = move_sign(a);
            b = move_sign(b);
            f.flag = $signed(a.num) < $signed(b.num);
          end
        end
        rau_pkg::OP_NEG: f = reduced_fraction(word_t'(0) - ln, ld);
        default: ;
      endcase
      return f;
    endfunction

    function void note_operands(rau_pkg::opcode_t op, word_t ln, word_t ld, word_t rn,
                                word_t rd);
      awaited_results.push_back(arithmetic_outcome(op, ln, ld, rn, rd));
    endfunction

    function void check_result(word_t num, word_t den, logic flag);
      fraction_result_t w;
      if (awaited_results.size() == 0) begin
        $error("result beat with nothing outstanding: %h/%h flag %b", num, den, flag);
        mismatches++;
        return;
      end
      w = awaited_results.pop_front();
      if (num !== w.num) begin
        $error("result_num: expected %h, actual %h", w.num, num);
        mismatches++;
      end
      if (den !== w.den) begin
        $error("result_den: expected %h, actual %h", w.den, den);
        mismatches++;
      end
      if (flag !== w.flag) begin
        $error("compare_true: expected %b, actual %b", w.flag, flag);
        mismatches++;
      end
    endfunction

    function int outstanding();
      return awaited_results.size();
    endfunction
  endclass

  logic  clk;
  logic  rst;
  logic  start;
  logic  busy;
  logic  [2:0] opcode;
  word_t left_num, left_den, right_num, right_den;
  logic  done;
  word_t result_num, result_den;
  logic  compare_true;

  fraction_scoreboard sb;
  bit                 idle_allowed;
  int unsigned        quiet_cycles;

  rational_arithmetic_unit_top u_dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .opcode       (opcode),
    .left_num     (left_num),
    .left_den     (left_den),
    .right_num    (right_num),
    .right_den    (right_den),
    .done         (done),
    .result_num   (result_num),
    .result_den   (result_den),
    .compare_true (compare_true)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Results cannot be held off, so every strobed cycle is checked.
  always @(posedge clk) begin
    if (!rst && done) sb.check_result(result_num, result_den, compare_true);
  end

  // Watchdog on cycles in which no beat moves in either direction.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= 60000) begin
      $display("tb: failure");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Drives one operand beat and waits for it to be taken, with random gaps before it.
  task automatic send_operands(rau_pkg::opcode_t op, word_t ln, word_t ld, word_t rn,
                               word_t rd);
    while (idle_allowed && $urandom_range(99) < 19) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start     <= 1'b1;
    opcode    <= op;
    left_num  <= ln;
    left_den  <= ld;
    right_num <= rn;
    right_den <= rd;
    do @(posedge clk); while (busy);
    sb.note_operands(op, ln, ld, rn, rd);
  endtask

  // Operand values: mostly small so that Euclid stays short, with wide and extreme ones.
  function automatic word_t random_value();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 45) return word_t'($urandom_range(2000)) - word_t'(1000);
    if (pick < 60) return word_t'($urandom_range(65535)) - word_t'(32768);
    if (pick < 85) return word_t'($urandom);
    case ($urandom_range(4))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'hffff_ffff;
      3: return 32'h0000_0001;
      default: return '0;
    endcase
  endfunction

  function automatic word_t random_denominator();
    return ($urandom_range(9) == 0) ? word_t'(0) : random_value();
  endfunction

  initial begin
    rau_pkg::opcode_t op;
    word_t            ln;
    sb           = new();
    idle_allowed = 1'b0;
    rst       <= 1'b1;
    start     <= 1'b0;
    opcode    <= rau_pkg::OP_ADD;
    left_num  <= '0;
    left_den  <= '0;
    right_num <= '0;
    right_den <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: each operation, NaN handling, zero over zero, a GCD of 2^31 and extremes.
    send_operands(rau_pkg::OP_ADD, 1, 2, 1, 3);
    send_operands(rau_pkg::OP_SUB, 1, 2, 1, 3);
    send_operands(rau_pkg::OP_MUL, -2, 3, 9, -4);
    send_operands(rau_pkg::OP_DIV, 3, 4, -6, 8);
    send_operands(rau_pkg::OP_EQ, 2, 4, -1, -2);
    send_operands(rau_pkg::OP_EQ, 2, 4, 1, 3);
    send_operands(rau_pkg::OP_LT, -1, 3, 1, 2);
    send_operands(rau_pkg::OP_LT, 5, -7, -5, 7);
    send_operands(rau_pkg::OP_NEG, 6, -4, 0, 1);
    send_operands(rau_pkg::OP_ADD, 5, 0, 7, -14);
    send_operands(rau_pkg::OP_ADD, 7, -14, 3, 0);
    send_operands(rau_pkg::OP_SUB, 5, 0, 0, 0);
    send_operands(rau_pkg::OP_SUB, 5, 0, 7, -14);
    send_operands(rau_pkg::OP_SUB, 9, 6, 1, 0);
    send_operands(rau_pkg::OP_MUL, 4, 0, 3, 5);
    send_operands(rau_pkg::OP_DIV, -4, 3, 0, 1);
    send_operands(rau_pkg::OP_NEG, 0, 0, 1, 1);
    send_operands(rau_pkg::OP_EQ, 1, 0, 1, 0);
    send_operands(rau_pkg::OP_LT, 1, 2, 3, 0);
    send_operands(rau_pkg::OP_NEG, 32'h8000_0000, 32'h8000_0000, 0, 1);
    send_operands(rau_pkg::OP_MUL, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff,
                  32'h8000_0000);
    send_operands(rau_pkg::OP_ADD, 32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff,
                  32'h7fff_ffff);
    send_operands(rau_pkg::OP_DIV, 32'hffff_ffff, 32'hffff_ffff, 32'h8000_0000,
                  32'h0000_0001);
    send_operands(rau_pkg::OP_EQ, 32'h8000_0000, 32'hffff_ffff, 32'h8000_0000,
                  32'h0000_0001);

    // Random beats; one stretch runs back to back and one pause drains the unit.
    for (int i = 0; i < 1730; i++) begin
      idle_allowed = !(i >= 500 && i < 800);
      if (i == 1000) begin
        start <= 1'b0;
        while (sb.outstanding() != 0) @(posedge clk);
      end
      op = rau_pkg::opcode_t'($urandom_range(6));
      ln = random_value();
      send_operands(op, ln, random_denominator(), random_value(), random_denominator());
    end
    start <= 1'b0;

    while (sb.outstanding() != 0) @(posedge clk);
    repeat (1000) @(posedge clk);
    if (sb.mismatches == 0 && sb.outstanding() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/rau_pkg.sv
hdl/rau_ctrl.sv
hdl/rau_dp.sv
hdl/rational_arithmetic_unit_top.sv
dv/testbench.sv
